>>> design/pld_pkg.sv
// shared types, constants and codes for the positional list
package pld_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int OPCODE_W   = 3;
  localparam int POS_W      = 8;
  localparam int WORD_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_W    = 5;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
  } pld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_free;
  } pld_stat_t;

endpackage

>>> design/pld_req_if.sv
// request channel: opcode, position and data word
interface pld_req_if import pld_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [POS_W-1:0]           position;
  logic signed [WORD_W-1:0]   value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

>>> design/pld_rsp_if.sv
// response channel: status, removed word and entry count
interface pld_rsp_if import pld_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [WORD_W-1:0]   removed_value;
  logic                       removed_valid;
  logic [ENTRY_W-1:0]         entry_count;

  modport source (output valid, output status, output removed_value, output removed_valid,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_value, input removed_valid,
                  input entry_count, output ready);
endinterface

>>> design/pld_ctrl.sv
// controller: takes one request word, then commits it once the result slot is free
module pld_ctrl import pld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  pld_stat_t stat_i,
  output logic      req_ready_o,
  output pld_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.res_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o  = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = stat_i.res_free;
      end
      default: ;
    endcase
  end

  a_commit_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> state_q == S_EXEC) else $error("commit outside execute");
  a_load_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_EXEC) else $error("load did not enter execute");
  a_no_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.commit)) else $error("load and commit together");

endmodule

>>> design/pld_dp.sv
// datapath: request latch, slot cell chain, count and result register
module pld_dp import pld_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pld_cmd_t                 cmd_i,
  output pld_stat_t                stat_o,
  input  logic [OPCODE_W-1:0]      req_opcode_i,
  input  logic [POS_W-1:0]         req_position_i,
  input  logic signed [WORD_W-1:0] req_value_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output logic [STATUS_W-1:0]      rsp_status_o,
  output logic signed [WORD_W-1:0] rsp_removed_value_o,
  output logic                     rsp_removed_valid_o,
  output logic [ENTRY_W-1:0]       rsp_entry_count_o
);

  logic [OPCODE_W-1:0]      op_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [WORD_W-1:0] value_q;

  logic signed [WORD_W-1:0] slots_q [LIST_DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;

  logic                     res_valid_q;
  status_e                  res_status_q;
  logic signed [WORD_W-1:0] res_removed_q;
  logic                     res_removed_valid_q;
  logic [ENTRY_W-1:0]       res_count_q;

  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic             full, empty, do_ins, do_del;
  logic [IDX_W-1:0] idx;
  status_e          status_d;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= req_opcode_i;
      pos_q   <= req_position_i;
      value_q <= req_value_i;
    end
  end

  // decode and range checks
  always_comb begin
    pos_ext  = CMP_W'(pos_q);
    cnt_ext  = CMP_W'(count_q);
    full     = (count_q == CNT_W'(LIST_DEPTH));
    empty    = (count_q == '0);
    do_ins   = 1'b0;
    do_del   = 1'b0;
    idx      = '0;
    status_d = ST_DONE;
    unique case (opcode_e'(op_q))
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = (opcode_e'(op_q) == OP_INS_FRONT) ? '0 : IDX_W'(count_q);
        end
      end
      OP_INS_POS: begin
        if (pos_q == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          status_d = ST_BADPOS;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = IDX_W'(pos_q - POS_W'(1));
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          do_del = 1'b1;
          idx    = (opcode_e'(op_q) == OP_DEL_FRONT) ? '0 : IDX_W'(count_q - CNT_W'(1));
        end
      end
      OP_DEL_POS: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_q == '0 || pos_ext > cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          idx    = IDX_W'(pos_q - POS_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.commit && do_ins) count_d = count_q + CNT_W'(1);
    else if (cmd_i.commit && do_del) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // slot cells: the insert point takes the request word, the others take from their lower or upper neighbour
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = value_q;
    end else begin : g_mid
      assign lower = slots_q[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign upper = slots_q[g];
    end else begin : g_up
      assign upper = slots_q[g+1];
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.commit && do_ins) begin
        if (IDX_W'(g) == idx) slots_q[g] <= value_q;
        else if (IDX_W'(g) > idx) slots_q[g] <= lower;
      end else if (cmd_i.commit && do_del) begin
        if (IDX_W'(g) >= idx) slots_q[g] <= upper;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      res_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q        <= status_d;
      res_removed_q       <= do_del ? slots_q[idx] : '0;
      res_removed_valid_q <= do_del;
      res_count_q         <= ENTRY_W'(count_d);
    end
  end

  assign stat_o.res_free     = !res_valid_q || rsp_ready_i;
  assign rsp_valid_o         = res_valid_q;
  assign rsp_status_o        = res_status_q;
  assign rsp_removed_value_o = res_removed_q;
  assign rsp_removed_valid_o = res_removed_valid_q;
  assign rsp_entry_count_o   = res_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH)) else $error("count beyond depth");
  a_count_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(count_q)) else $error("count moved without commit");
  a_removed_means_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_removed_valid_q |-> res_status_q == ST_DONE)
    else $error("removed word with error status");

endmodule

>>> design/positional_list_insert_delete_top.sv
// positional list top level: controller, datapath and channel hookup
// path: a request word is held in the request latch and its result word in the result register
// requests: a new request word is taken only in idle, once the execute step of the last one
//   has committed; a waiting result stalls the execute step only when it is not taken
// reset: asynchronous, clears the entry count, controller state and result valid;
//   slot contents are left as they are and only occupied slots are ever read
module positional_list_insert_delete_top import pld_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  pld_req_if.sink    req_i,
  pld_rsp_if.source  rsp_o
);

  pld_cmd_t  cmd;
  pld_stat_t stat;

  // sequencing: idle takes a word, execute commits when the result register frees
  pld_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .stat_i      (stat),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  // slot chain, count and result register
  pld_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .req_opcode_i        (req_i.opcode),
    .req_position_i      (req_i.position),
    .req_value_i         (req_i.value),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_status_o        (rsp_o.status),
    .rsp_removed_value_o (rsp_o.removed_value),
    .rsp_removed_valid_o (rsp_o.removed_valid),
    .rsp_entry_count_o   (rsp_o.entry_count)
  );

endmodule

>>> tb/pld_list_mirror_pkg.sv
// behavioural mirror of the positional list that checks response words
package pld_list_mirror_pkg;
  import pld_pkg::*;

  class pld_list_mirror;
    typedef struct {
      status_e                  status;
      logic signed [WORD_W-1:0] removed_value;
      logic                     removed_valid;
      logic [ENTRY_W-1:0]       entry_count;
    } answer_t;

    logic signed [WORD_W-1:0] slots [LIST_DEPTH];
    int unsigned              fill;
    answer_t                  pending_answers[$];
    int unsigned              errors;
    int unsigned              requests_taken;
    int unsigned              answers_checked;
    int unsigned              peak_fill;
    int unsigned              status_seen [4];

    function new();
      fill            = 0;
      errors          = 0;
      requests_taken  = 0;
      answers_checked = 0;
      peak_fill       = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // open a gap at idx and place the word there
    function void insert_at(int unsigned idx, logic signed [WORD_W-1:0] word);
      for (int unsigned i = fill; i > idx; i--) slots[i] = slots[i-1];
      slots[idx] = word;
      fill++;
    endfunction

    // close the gap left by the word at idx
    function logic signed [WORD_W-1:0] remove_at(int unsigned idx);
      logic signed [WORD_W-1:0] word;
      word = slots[idx];
      for (int unsigned i = idx; i + 1 < fill; i++) slots[i] = slots[i+1];
      fill--;
      return word;
    endfunction

    function void note_request(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [WORD_W-1:0] value);
      answer_t a;
      a.status        = ST_DONE;
      a.removed_value = '0;
      a.removed_valid = 1'b0;
      case (op)
        OP_INS_FRONT, OP_INS_BACK: begin
          if (fill >= LIST_DEPTH) a.status = ST_FULL;
          else insert_at((op == OP_INS_FRONT) ? 0 : fill, value);
        end
        OP_INS_POS: begin
          // range is judged before fullness
          if (pos == 0 || pos > fill + 1) a.status = ST_BADPOS;
          else if (fill >= LIST_DEPTH) a.status = ST_FULL;
          else insert_at(pos - 1, value);
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (fill == 0) begin
            a.status = ST_EMPTY;
          end else begin
            a.removed_value = remove_at((op == OP_DEL_FRONT) ? 0 : fill - 1);
            a.removed_valid = 1'b1;
          end
        end
        OP_DEL_POS: begin
          if (fill == 0) begin
            a.status = ST_EMPTY;
          end else if (pos == 0 || pos > fill) begin
            a.status = ST_BADPOS;
          end else begin
            a.removed_value = remove_at(pos - 1);
            a.removed_valid = 1'b1;
          end
        end
        default: ;
      endcase
      a.entry_count = ENTRY_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      status_seen[a.status]++;
      requests_taken++;
      pending_answers.push_back(a);
    endfunction

    function void check_answer(logic [STATUS_W-1:0] status, logic signed [WORD_W-1:0] removed_value,
                               logic removed_valid, logic [ENTRY_W-1:0] entry_count);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $error("response word with no request outstanding");
        errors++;
        return;
      end
      a = pending_answers.pop_front();
      answers_checked++;
      if (status !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, status);
        errors++;
      end
      if (removed_value !== a.removed_value) begin
        $error("removed_value: expected %0d, got %0d", a.removed_value, removed_value);
        errors++;
      end
      if (removed_valid !== a.removed_valid) begin
        $error("removed_valid: expected %0d, got %0d", a.removed_valid, removed_valid);
        errors++;
      end
      if (entry_count !== a.entry_count) begin
        $error("entry_count: expected %0d, got %0d", a.entry_count, entry_count);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/tb_positional_list_insert_delete_top.sv
// testbench for the positional list: directed and random requests against a mirror
module tb_positional_list_insert_delete_top;
  import pld_pkg::*;
  import pld_list_mirror_pkg::*;

  // the two opcodes the block does not define, still legal on the wire
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 80;

  bit   clk_i = 1'b0;
  logic rst_ni;

  pld_req_if req_if ();
  pld_rsp_if rsp_if ();

  positional_list_insert_delete_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  pld_list_mirror mirror = new();

  // shared between the sender and the receiver
  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;

  always #1 clk_i = ~clk_i;

  // mostly back to back, now and then a short pause, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one request word and hold it until the block takes it
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [WORD_W-1:0] value);
    int gap;
    req_if.valid    <= 1'b1;
    req_if.opcode   <= op;
    req_if.position <= pos;
    req_if.value    <= value;
    do @(posedge clk_i); while (!req_if.ready);
    mirror.note_request(op, pos, value);
    gap = idling_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random request biased towards inserts by ins_weight percent; positions mostly land
  // inside the list as it stands, the rest are zero, just past the end or anywhere
  task automatic send_random(input int ins_weight);
    logic [OPCODE_W-1:0]      op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] value;
    int                       r;
    int                       limit;
    r = $urandom_range(0, 99);
    if (r < 3) op = OPCODE_W'($urandom_range(OP_SPARE_6, OP_SPARE_7));
    else if (r < 3 + ins_weight) op = OPCODE_W'($urandom_range(OP_INS_FRONT, OP_INS_POS));
    else op = OPCODE_W'($urandom_range(OP_DEL_FRONT, OP_DEL_POS));
    limit = (op == OP_INS_POS) ? mirror.fill + 1 : mirror.fill;
    r = $urandom_range(0, 99);
    if (r < 75 && limit >= 1) pos = POS_W'($urandom_range(1, limit));
    else if (r < 85) pos = '0;
    else if (r < 93) pos = POS_W'(limit + 1);
    else pos = POS_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       value = 32'sh8000_0000;
      1:       value = 32'sh7fff_ffff;
      2:       value = -32'sd1;
      default: value = $urandom;
    endcase
    send_request(op, pos, value);
  endtask

  // hold back the sender until every outstanding response has been seen
  task automatic drain();
    while (mirror.pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n, input int ins_weight, input bit idle, input bit hold);
    idling_on = idle;
    for (int i = 0; i < n; i++) begin
      if (hold && i == 10) hold_request = 1'b1;
      send_random(ins_weight);
    end
    req_if.valid <= 1'b0;
    drain();
  endtask

  // receiver: checks each response word and throttles ready
  initial begin
    int stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready)
        mirror.check_answer(rsp_if.status, rsp_if.removed_value, rsp_if.removed_valid,
                            rsp_if.entry_count);
      // a long hold-off lets the result path and then the request path back up
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idling_on) begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          stall_left--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // main stimulus
  initial begin
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_INS_FRONT;
    req_if.position = '0;
    req_if.value    = '0;
    rst_ni          = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list corner cases first
    send_request(OP_DEL_FRONT, 8'd0,   32'sd0);
    send_request(OP_DEL_BACK,  8'd0,   32'sd0);
    send_request(OP_DEL_POS,   8'd255, 32'sd0);       // empty wins over a bad position
    send_request(OP_INS_POS,   8'd0,   32'sd1);
    send_request(OP_INS_POS,   8'd2,   32'sd2);
    send_request(OP_SPARE_6,   8'd1,   32'sd3);
    // build up a small list with the extreme words
    send_request(OP_INS_POS,   8'd1,   32'sh8000_0000);
    send_request(OP_INS_FRONT, 8'd0,   32'sh7fff_ffff);
    send_request(OP_INS_BACK,  8'd0,   32'sd0);
    send_request(OP_INS_POS,   8'd4,   -32'sd1);      // insert just past the last entry
    send_request(OP_INS_POS,   8'd255, 32'sd4);
    send_request(OP_DEL_POS,   8'd0,   32'sd0);
    send_request(OP_DEL_POS,   8'd5,   32'sd0);       // one past the end on delete
    send_request(OP_SPARE_7,   8'd255, 32'sh5555_aaaa);
    send_request(OP_INS_POS,   8'd2,   32'shaaaa_5555);
    // take it apart again from the middle and both ends
    send_request(OP_DEL_POS,   8'd3,   32'sd0);
    send_request(OP_DEL_BACK,  8'd0,   32'sd0);
    send_request(OP_DEL_FRONT, 8'd0,   32'sd0);
    send_request(OP_DEL_POS,   8'd2,   32'sd0);
    send_request(OP_DEL_POS,   8'd1,   32'sd0);
    send_request(OP_INS_POS,   8'd128, 32'sd5);
    req_if.valid <= 1'b0;
    drain();

    // random phases: fill to the top, drain to empty, and a mix in between
    run_phase(90,  75, 1'b1, 1'b0);
    run_phase(100, 48, 1'b0, 1'b0);
    run_phase(90,  20, 1'b1, 1'b0);
    run_phase(80,  70, 1'b0, 1'b1);
    run_phase(90,  48, 1'b1, 1'b0);
    run_phase(80,  25, 1'b1, 1'b1);

    // let any stray response word show up before judging
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests, %0d responses checked, peak fill %0d of %0d",
             mirror.requests_taken, mirror.answers_checked, mirror.peak_fill, LIST_DEPTH);
    $display("statuses done %0d, empty %0d, bad position %0d, full %0d",
             mirror.status_seen[ST_DONE], mirror.status_seen[ST_EMPTY],
             mirror.status_seen[ST_BADPOS], mirror.status_seen[ST_FULL]);
    if (mirror.errors == 0 && mirror.pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/pld_pkg.sv
design/pld_req_if.sv
design/pld_rsp_if.sv
design/pld_ctrl.sv
design/pld_dp.sv
design/positional_list_insert_delete_top.sv
tb/pld_list_mirror_pkg.sv
tb/tb_positional_list_insert_delete_top.sv
